// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk_i, off while in reset.
`define AFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Concurrent check on clk_i that also holds during reset.
`define AFT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

// ===== rtl/aft_pkg.sv =====
`default_nettype none

package aft_pkg;

  localparam int SAMPLES_PER_READING = 20;
  localparam int BAND_MAX_TENTHS     = 100;

  localparam int OFFSET_TENTHS  = 2730;
  localparam int SCALE          = 5;
  localparam int SETPOINT_MIN   = 180;
  localparam int SETPOINT_MAX   = 400;
  localparam int SETPOINT_STEP  = 10;
  localparam int SETPOINT_RESET = 250;
  localparam int BAND_MIN       = 5;
  localparam int BAND_STEP      = 5;
  localparam int BAND_RESET     = 10;

  localparam int FUNC_W   = 2;
  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 15;
  localparam int CNT_W    = 5;
  localparam int TEMP_W   = 13;
  localparam int SETP_W   = 9;
  localparam int BAND_W   = 7;
  localparam int SCALED_W = SUM_W + 3;
  localparam int THR_W    = SCALED_W;

  // floor(SCALE * sum / SAMPLES_PER_READING) as one multiply by a rounded-up reciprocal
  localparam int QK     = SCALED_W + $clog2(SAMPLES_PER_READING);
  localparam int RECIP  = ((1 << QK) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING;
  localparam int QMUL   = SCALE * RECIP;
  localparam int QMUL_W = $clog2(QMUL + 1);
  localparam int PROD_W = SUM_W + QMUL_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_UP     = 2'd1,
    FUNC_DOWN   = 2'd2,
    FUNC_MODE   = 2'd3
  } func_e;

  typedef struct packed {
    logic                fire;
    func_e               func;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [THR_W-1:0] hi;
    logic [THR_W-1:0] lo;
  } thr_t;

  typedef struct packed {
    logic [SETP_W-1:0] setpoint;
    logic [BAND_W-1:0] band;
    logic              editing;
  } ctrl_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic              fan;
    logic              led;
  } sense_t;

endpackage

`default_nettype wire

// ===== rtl/aft_in_if.sv =====
`default_nettype none

interface aft_in_if;
  logic                         valid;
  logic                         ready;
  logic [aft_pkg::FUNC_W-1:0]   func;
  logic [aft_pkg::SAMPLE_W-1:0] adc_sample;

  modport source (output valid, func, adc_sample, input ready);
  modport sink   (input valid, func, adc_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/aft_out_if.sv =====
`default_nettype none

interface aft_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [aft_pkg::TEMP_W-1:0] temperature_tenths;
  logic        [aft_pkg::SETP_W-1:0] setpoint_tenths;
  logic        [aft_pkg::BAND_W-1:0] band_tenths;
  logic                              fan_on;
  logic                              editing_setpoint;
  logic                              led;

  modport source (output valid, temperature_tenths, setpoint_tenths, band_tenths,
                  fan_on, editing_setpoint, led, input ready);
  modport sink   (input valid, temperature_tenths, setpoint_tenths, band_tenths,
                  fan_on, editing_setpoint, led, output ready);
endinterface

`default_nettype wire

// ===== rtl/aft_ctrl.sv =====
`default_nettype none

module aft_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire aft_pkg::item_t item_i,
  output aft_pkg::ctrl_t      nxt_o,
  output aft_pkg::thr_t       thr_o
);

  function automatic logic [aft_pkg::THR_W-1:0] thr_calc(
    input logic [aft_pkg::SETP_W-1:0] sp,
    input logic [aft_pkg::BAND_W-1:0] bd,
    input logic                       upper
  );
    logic [aft_pkg::THR_W-1:0] base;
    if (upper) begin
      base = aft_pkg::THR_W'(sp) + aft_pkg::THR_W'(bd)
           + aft_pkg::THR_W'(aft_pkg::OFFSET_TENTHS);
    end else begin
      base = aft_pkg::THR_W'(sp) - aft_pkg::THR_W'(bd)
           + aft_pkg::THR_W'(aft_pkg::OFFSET_TENTHS);
    end
    return aft_pkg::THR_W'(base * aft_pkg::THR_W'(aft_pkg::SAMPLES_PER_READING));
  endfunction

  logic [aft_pkg::SETP_W-1:0] setpoint_q, setpoint_d;
  logic [aft_pkg::BAND_W-1:0] band_q, band_d;
  logic                       edit_q, edit_d;
  aft_pkg::thr_t              thr_q, thr_d;
  logic [aft_pkg::SETP_W:0]   sp_up;
  logic [aft_pkg::BAND_W:0]   bd_up;

  always_comb begin
    setpoint_d = setpoint_q;
    band_d     = band_q;
    edit_d     = edit_q;
    sp_up      = {1'b0, setpoint_q} + (aft_pkg::SETP_W + 1)'(aft_pkg::SETPOINT_STEP);
    bd_up      = {1'b0, band_q} + (aft_pkg::BAND_W + 1)'(aft_pkg::BAND_STEP);
    if (item_i.fire) begin
      unique case (item_i.func)
        aft_pkg::FUNC_UP: begin
          if (edit_q) begin
            if (sp_up > (aft_pkg::SETP_W + 1)'(aft_pkg::SETPOINT_MAX)) begin
              setpoint_d = aft_pkg::SETP_W'(aft_pkg::SETPOINT_MAX);
            end else begin
              setpoint_d = sp_up[aft_pkg::SETP_W-1:0];
            end
          end else begin
            if (bd_up > (aft_pkg::BAND_W + 1)'(aft_pkg::BAND_MAX_TENTHS)) begin
              band_d = aft_pkg::BAND_W'(aft_pkg::BAND_MAX_TENTHS);
            end else begin
              band_d = bd_up[aft_pkg::BAND_W-1:0];
            end
          end
        end
        aft_pkg::FUNC_DOWN: begin
          if (edit_q) begin
            if (setpoint_q < aft_pkg::SETP_W'(aft_pkg::SETPOINT_MIN
                                              + aft_pkg::SETPOINT_STEP)) begin
              setpoint_d = aft_pkg::SETP_W'(aft_pkg::SETPOINT_MIN);
            end else begin
              setpoint_d = setpoint_q - aft_pkg::SETP_W'(aft_pkg::SETPOINT_STEP);
            end
          end else if (band_q >= aft_pkg::BAND_W'(aft_pkg::BAND_MIN
                                                  + aft_pkg::BAND_STEP)) begin
            band_d = band_q - aft_pkg::BAND_W'(aft_pkg::BAND_STEP);
          end
        end
        aft_pkg::FUNC_MODE: edit_d = ~edit_q;
        default: ;
      endcase
    end
    thr_d.hi = thr_calc(setpoint_d, band_d, 1'b1);
    thr_d.lo = thr_calc(setpoint_d, band_d, 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= aft_pkg::SETP_W'(aft_pkg::SETPOINT_RESET);
      band_q     <= aft_pkg::BAND_W'(aft_pkg::BAND_RESET);
      edit_q     <= 1'b1;
      thr_q.hi   <= thr_calc(aft_pkg::SETP_W'(aft_pkg::SETPOINT_RESET),
                             aft_pkg::BAND_W'(aft_pkg::BAND_RESET), 1'b1);
      thr_q.lo   <= thr_calc(aft_pkg::SETP_W'(aft_pkg::SETPOINT_RESET),
                             aft_pkg::BAND_W'(aft_pkg::BAND_RESET), 1'b0);
    end else begin
      setpoint_q <= setpoint_d;
      band_q     <= band_d;
      edit_q     <= edit_d;
      thr_q      <= thr_d;
    end
  end

  assign nxt_o.setpoint = setpoint_d;
  assign nxt_o.band     = band_d;
  assign nxt_o.editing  = edit_d;
  assign thr_o          = thr_q;

endmodule

`default_nettype wire

// ===== rtl/aft_accum.sv =====
`default_nettype none

module aft_accum (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire aft_pkg::item_t item_i,
  input  wire aft_pkg::thr_t  thr_i,
  output logic                done_o,
  output aft_pkg::sense_t     nxt_o
);

  logic [aft_pkg::SUM_W-1:0]    sum_q;
  logic [aft_pkg::CNT_W-1:0]    cnt_q;
  logic [aft_pkg::TEMP_W-1:0]   reading_q, reading_d;
  logic                         fan_q, fan_d;
  logic                         blink_q, blink_d;
  logic [aft_pkg::SUM_W:0]      sum_ext;
  logic [aft_pkg::CNT_W:0]      cnt_ext;
  logic [aft_pkg::SCALED_W-1:0] scaled;
  logic [aft_pkg::PROD_W-1:0]   prod;
  logic [aft_pkg::TEMP_W-1:0]   quo;
  logic [aft_pkg::TEMP_W:0]     diff;
  logic                         take, close;

  assign sum_ext = {1'b0, sum_q} + (aft_pkg::SUM_W + 1)'(item_i.sample);
  assign cnt_ext = {1'b0, cnt_q} + (aft_pkg::CNT_W + 1)'(1);
  assign done_o  = cnt_ext >= (aft_pkg::CNT_W + 1)'(aft_pkg::SAMPLES_PER_READING);

  assign scaled = aft_pkg::SCALED_W'(aft_pkg::SCALED_W'(sum_ext[aft_pkg::SUM_W-1:0])
                * aft_pkg::SCALED_W'(aft_pkg::SCALE));
  assign prod   = aft_pkg::PROD_W'(sum_ext[aft_pkg::SUM_W-1:0])
                * aft_pkg::PROD_W'(aft_pkg::QMUL);
  assign quo    = prod[aft_pkg::QK +: aft_pkg::TEMP_W];
  assign diff   = {1'b0, quo} - (aft_pkg::TEMP_W + 1)'(aft_pkg::OFFSET_TENTHS);

  assign take  = item_i.fire && (item_i.func == aft_pkg::FUNC_SAMPLE);
  assign close = take && done_o;

  always_comb begin
    reading_d = reading_q;
    fan_d     = fan_q;
    blink_d   = blink_q;
    if (close) begin
      reading_d = diff[aft_pkg::TEMP_W-1:0];
      blink_d   = ~blink_q;
      if (scaled > thr_i.hi) begin
        fan_d = 1'b1;
      end else if (scaled < thr_i.lo) begin
        fan_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      cnt_q     <= '0;
      reading_q <= '0;
      fan_q     <= 1'b0;
      blink_q   <= 1'b1;
    end else begin
      reading_q <= reading_d;
      fan_q     <= fan_d;
      blink_q   <= blink_d;
      if (close) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else if (take) begin
        sum_q <= sum_ext[aft_pkg::SUM_W-1:0];
        cnt_q <= cnt_ext[aft_pkg::CNT_W-1:0];
      end
    end
  end

  assign nxt_o.temp = reading_d;
  assign nxt_o.fan  = fan_d;
  assign nxt_o.led  = blink_d;

endmodule

`default_nettype wire

// ===== rtl/averaging_fan_thermostat.sv =====
// Fan thermostat with hysteresis. Takes one item per clock unless a stalled
// result holds it: an ADC sample or a button press (up, down, mode toggle).
// Each group of SAMPLES_PER_READING samples yields one reading in tenths of
// a degree and one result; samples inside a group yield none, and every
// button press yields one result carrying the new setpoint, band and edit
// mode. An item passes an input register and a result register, and one
// result per cycle is sustained while the sink stays ready. The reading, the
// fan compare and the setpoint/band update are combinational between those
// two registers; the fan thresholds are kept in registers next to setpoint
// and band. A stalled result holds only items that produce a result.
`default_nettype none

module averaging_fan_thermostat (
  input wire logic clk_i,
  input wire logic rst_ni,
  aft_in_if.sink   in_i,
  aft_out_if.source out_o
);

  logic                         in_vld_q;
  aft_pkg::func_e               in_func_q;
  logic [aft_pkg::SAMPLE_W-1:0] in_sample_q;
  logic                         out_vld_q;
  logic [aft_pkg::TEMP_W-1:0]   temp_q;
  logic [aft_pkg::SETP_W-1:0]   setp_q;
  logic [aft_pkg::BAND_W-1:0]   band_q;
  logic                         fan_q, edit_q, led_q;

  aft_pkg::item_t  item;
  aft_pkg::thr_t   thr;
  aft_pkg::ctrl_t  ctrl_nxt;
  aft_pkg::sense_t sense_nxt;
  logic            done, has_res, advance, in_ready;

  assign has_res  = (in_func_q != aft_pkg::FUNC_SAMPLE) || done;
  assign advance  = in_vld_q && (!has_res || !out_vld_q || out_o.ready);
  assign in_ready = !in_vld_q || advance;

  assign item.fire   = advance;
  assign item.func   = in_func_q;
  assign item.sample = in_sample_q;

  aft_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .nxt_o  (ctrl_nxt),
    .thr_o  (thr)
  );

  aft_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item),
    .thr_i  (thr),
    .done_o (done),
    .nxt_o  (sense_nxt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance && has_res) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_func_q   <= aft_pkg::func_e'(in_i.func);
      in_sample_q <= in_i.adc_sample;
    end
    if (advance && has_res) begin
      temp_q <= sense_nxt.temp;
      setp_q <= ctrl_nxt.setpoint;
      band_q <= ctrl_nxt.band;
      fan_q  <= sense_nxt.fan;
      edit_q <= ctrl_nxt.editing;
      led_q  <= sense_nxt.led;
    end
  end

  assign in_i.ready               = in_ready;
  assign out_o.valid              = out_vld_q;
  assign out_o.temperature_tenths = $signed(temp_q);
  assign out_o.setpoint_tenths    = setp_q;
  assign out_o.band_tenths        = band_q;
  assign out_o.fan_on             = fan_q;
  assign out_o.editing_setpoint   = edit_q;
  assign out_o.led                = led_q;

endmodule

`default_nettype wire

// ===== rtl/aft_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module aft_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire logic signed [aft_pkg::TEMP_W-1:0] temp_i,
  input wire logic        [aft_pkg::SETP_W-1:0] setpoint_i,
  input wire logic        [aft_pkg::BAND_W-1:0] band_i,
  input wire logic                              fan_i,
  input wire logic                              edit_i,
  input wire logic                              led_i
);

  localparam int TempLo = -aft_pkg::OFFSET_TENTHS;
  localparam int TempHi = aft_pkg::SCALE * ((1 << aft_pkg::SAMPLE_W) - 1)
                        - aft_pkg::OFFSET_TENTHS;

  `AFT_ASSERT_RST(a_no_valid_in_reset, !rst_ni |-> !out_valid_i, "result valid during reset")
  `AFT_ASSERT(a_hold_on_stall, out_valid_i && !out_ready_i |=> out_valid_i && $stable(temp_i) && $stable(setpoint_i) && $stable(band_i) && $stable(fan_i) && $stable(edit_i) && $stable(led_i), "stalled result changed")
  `AFT_ASSERT(a_setpoint_range, out_valid_i |-> (setpoint_i >= aft_pkg::SETP_W'(aft_pkg::SETPOINT_MIN)) && (setpoint_i <= aft_pkg::SETP_W'(aft_pkg::SETPOINT_MAX)), "setpoint out of range")
  `AFT_ASSERT(a_band_range, out_valid_i |-> (band_i >= aft_pkg::BAND_W'(aft_pkg::BAND_MIN)) && (band_i <= aft_pkg::BAND_W'(aft_pkg::BAND_MAX_TENTHS)), "band out of range")
  `AFT_ASSERT(a_temp_range, out_valid_i |-> (int'(temp_i) >= TempLo) && (int'(temp_i) <= TempHi), "reading out of range")

endmodule

bind averaging_fan_thermostat aft_checker u_aft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .temp_i      (out_o.temperature_tenths),
  .setpoint_i  (out_o.setpoint_tenths),
  .band_i      (out_o.band_tenths),
  .fan_i       (out_o.fan_on),
  .edit_i      (out_o.editing_setpoint),
  .led_i       (out_o.led)
);

`default_nettype wire

// ===== bench/tb_averaging_fan_thermostat.sv =====
`timescale 1ns / 100ps

module tb_averaging_fan_thermostat;
  import aft_pkg::*;

  localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
  localparam int RANDOM_ITEMS = 400;
  localparam int DIR_ROWS    = 9;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic        [SETP_W-1:0] setp;
    logic        [BAND_W-1:0] band;
    logic                     fan;
    logic                     editing;
    logic                     led;
  } status_t;

  typedef struct {
    func_e               func;
    logic [SAMPLE_W-1:0] sample;
    int                  reps;
    bit                  typed_want;
    status_t             want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  aft_in_if  in_if ();
  aft_out_if out_if ();

  averaging_fan_thermostat u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic        [SUM_W-1:0]  sum_acc  = '0;
  logic        [CNT_W-1:0]  cnt_acc  = '0;
  logic signed [TEMP_W-1:0] temp_now = '0;
  logic        [SETP_W-1:0] setp_now = SETP_W'(SETPOINT_RESET);
  logic        [BAND_W-1:0] band_now = BAND_W'(BAND_RESET);
  logic                     edit_now = 1'b1;
  logic                     fan_now  = 1'b0;
  logic                     led_now  = 1'b1;

  status_t  status_due[$];
  dir_row_t dir_table [DIR_ROWS];
  int       mismatches = 0;
  int       items_sent = 0;
  bit       steady_src = 1'b0;
  bit       steady_sink = 1'b0;

  function automatic bit thermo_advance(input func_e f, input logic [SAMPLE_W-1:0] s,
                                        output status_t st);
    int unsigned acc;
    int unsigned scaled;
    int unsigned hi;
    int unsigned lo;
    int          nxt;
    st = '0;
    case (f)
      FUNC_SAMPLE: begin
        acc = int'(sum_acc) + int'(s);
        if (int'(cnt_acc) + 1 < SAMPLES_PER_READING) begin
          sum_acc = SUM_W'(acc);
          cnt_acc = cnt_acc + 1'b1;
          return 1'b0;
        end
        scaled = acc * SCALE;
        hi = SAMPLES_PER_READING * (int'(setp_now) + int'(band_now) + OFFSET_TENTHS);
        lo = SAMPLES_PER_READING * (int'(setp_now) - int'(band_now) + OFFSET_TENTHS);
        led_now  = ~led_now;
        temp_now = TEMP_W'(int'(scaled / SAMPLES_PER_READING) - OFFSET_TENTHS);
        if (scaled > hi) begin
          fan_now = 1'b1;
        end else if (scaled < lo) begin
          fan_now = 1'b0;
        end
        sum_acc = '0;
        cnt_acc = '0;
      end
      FUNC_UP: begin
        if (edit_now) begin
          nxt = int'(setp_now) + SETPOINT_STEP;
          setp_now = SETP_W'((nxt > SETPOINT_MAX) ? SETPOINT_MAX : nxt);
        end else begin
          nxt = int'(band_now) + BAND_STEP;
          band_now = BAND_W'((nxt > BAND_MAX_TENTHS) ? BAND_MAX_TENTHS : nxt);
        end
      end
      FUNC_DOWN: begin
        if (edit_now) begin
          if (int'(setp_now) < SETPOINT_MIN + SETPOINT_STEP) begin
            setp_now = SETP_W'(SETPOINT_MIN);
          end else begin
            setp_now = setp_now - SETP_W'(SETPOINT_STEP);
          end
        end else if (int'(band_now) >= BAND_MIN + BAND_STEP) begin
          band_now = band_now - BAND_W'(BAND_STEP);
        end
      end
      default: begin
        edit_now = ~edit_now;
      end
    endcase
    st.temp    = temp_now;
    st.setp    = setp_now;
    st.band    = band_now;
    st.fan     = fan_now;
    st.editing = edit_now;
    st.led     = led_now;
    return 1'b1;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) begin
      return int'($urandom_range(1, 3));
    end
    return int'($urandom_range(8, 30));
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) begin
      $display("%0t mismatch: %s", $time, what);
    end
  endtask

  task automatic push_item(input func_e f, input logic [SAMPLE_W-1:0] s,
                           input bit use_want, input status_t want);
    status_t st;
    bit      got;
    int      n;
    in_if.valid      <= 1'b1;
    in_if.func       <= f;
    in_if.adc_sample <= s;
    do @(posedge clk_i); while (!in_if.ready);
    got = thermo_advance(f, s, st);
    if (got) begin
      status_due.push_back(use_want ? want : st);
    end
    items_sent++;
    n = (!steady_src && $urandom_range(0, 1) == 0) ? idle_len() : 0;
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (status_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] near_sample(input int bias);
    int v;
    v = (int'(setp_now) + OFFSET_TENTHS) / SCALE + bias + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return SAMPLE_W'(v);
  endfunction

  task automatic random_group();
    int                  style;
    int                  spread;
    int                  bias;
    int                  left;
    int                  burst;
    func_e               f;
    logic [SAMPLE_W-1:0] pick;
    style  = int'($urandom_range(0, 9));
    spread = int'(band_now) / SCALE + 3;
    bias   = int'($urandom_range(0, 2 * spread)) - spread;
    left   = SAMPLES_PER_READING - int'(cnt_acc);
    if ($urandom_range(0, 9) == 0) begin
      f = $urandom_range(0, 1) ? FUNC_UP : FUNC_DOWN;
      burst = int'($urandom_range(1, 25));
      repeat (burst) push_item(f, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), 1'b0, '0);
    end
    repeat (left) begin
      if ($urandom_range(0, 11) == 0) begin
        f = func_e'($urandom_range(1, 3));
        push_item(f, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), 1'b0, '0);
      end
      if (style < 7) begin
        pick = near_sample(bias);
      end else if (style < 9) begin
        pick = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      end else begin
        pick = $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
      end
      push_item(FUNC_SAMPLE, pick, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    status_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (status_due.size() == 0) begin
        flag_mismatch("result transfer with nothing expected");
      end else begin
        want = status_due.pop_front();
        if (out_if.temperature_tenths !== want.temp)
          flag_mismatch($sformatf("temperature_tenths %0d, want %0d",
                                  out_if.temperature_tenths, want.temp));
        if (out_if.setpoint_tenths !== want.setp)
          flag_mismatch($sformatf("setpoint_tenths %0d, want %0d",
                                  out_if.setpoint_tenths, want.setp));
        if (out_if.band_tenths !== want.band)
          flag_mismatch($sformatf("band_tenths %0d, want %0d",
                                  out_if.band_tenths, want.band));
        if (out_if.fan_on !== want.fan)
          flag_mismatch($sformatf("fan_on %b, want %b", out_if.fan_on, want.fan));
        if (out_if.editing_setpoint !== want.editing)
          flag_mismatch($sformatf("editing_setpoint %b, want %b",
                                  out_if.editing_setpoint, want.editing));
        if (out_if.led !== want.led)
          flag_mismatch($sformatf("led %b, want %b", out_if.led, want.led));
      end
    end
  end

  initial begin : sink_ctl
    int n;
    out_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (steady_sink || $urandom_range(0, 2) != 0) begin
        out_if.ready <= 1'b1;
        n = int'($urandom_range(1, 10));
      end else begin
        out_if.ready <= 1'b0;
        n = idle_len();
      end
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni          <= 1'b0;
    in_if.valid      = 1'b0;
    in_if.func       = FUNC_SAMPLE;
    in_if.adc_sample = '0;
    dir_table = '{
      '{FUNC_MODE,   10'd0,    1,  1'b1, '{13'sd0, 9'd250, 7'd10, 1'b0, 1'b0, 1'b1}},
      '{FUNC_DOWN,   10'd0,    1,  1'b1, '{13'sd0, 9'd250, 7'd5,  1'b0, 1'b0, 1'b1}},
      '{FUNC_DOWN,   10'd1023, 1,  1'b1, '{13'sd0, 9'd250, 7'd5,  1'b0, 1'b0, 1'b1}},
      '{FUNC_UP,     10'd0,    1,  1'b0, '0},
      '{FUNC_MODE,   10'd0,    1,  1'b0, '0},
      '{FUNC_UP,     10'd0,    1,  1'b0, '0},
      '{FUNC_DOWN,   10'd0,    1,  1'b0, '0},
      '{FUNC_SAMPLE, 10'd0,    20, 1'b1, '{-13'sd2730, 9'd250, 7'd10, 1'b0, 1'b1, 1'b0}},
      '{FUNC_SAMPLE, 10'd1023, 20, 1'b1, '{13'sd2385, 9'd250, 7'd10, 1'b1, 1'b1, 1'b1}}
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      for (int k = 0; k < dir_table[r].reps; k++) begin
        push_item(dir_table[r].func, dir_table[r].sample,
                  dir_table[r].typed_want && (k == dir_table[r].reps - 1), dir_table[r].want);
      end
    end
    drain_results();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady_src  = ($urandom_range(0, 6) == 0);
      steady_sink = ($urandom_range(0, 6) == 0);
      random_group();
      if ($urandom_range(0, 19) == 0) begin
        drain_results();
      end
    end

    steady_sink = 1'b1;
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
